// File: rtl/ssd_pkg.sv
// shared widths, types, constants and helpers for the segment distance core
package ssd_pkg;

    localparam int CW  = 32;
    localparam int DW  = CW + 1;
    localparam int PW  = 68;
    localparam int HW  = PW / 2;
    localparam int WW  = 2 * PW;
    localparam int QW  = 33;
    localparam int SW  = 72;
    localparam int RW  = SW / 2;
    localparam int OW  = CW + 1;

    localparam int MUL_LAT  = 3;
    localparam int DIV_LAT  = QW;
    localparam int SQRT_LAT = RW;
    localparam int LATENCY  = 12 + 2 * MUL_LAT + DIV_LAT + SQRT_LAT + 1;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [PW-1:0] t_dot;
    typedef logic signed [WW-1:0] t_wide;
    typedef logic [WW-1:0]        t_uwide;
    typedef logic [QW-1:0]        t_quo;

    localparam logic [1:0] SC_INT = 2'd0;
    localparam logic [1:0] SC_F2  = 2'd1;
    localparam logic [1:0] SC_F4  = 2'd2;

    localparam t_uwide EPS_INV  = WW'(100000000);
    localparam t_uwide TINY_INT = WW'(1);
    localparam t_uwide TINY_F2  = ((WW'(1) << 32) + EPS_INV - WW'(1)) / EPS_INV;
    localparam t_uwide TINY_F4  = ((WW'(1) << 64) + EPS_INV - WW'(1)) / EPS_INV;

    localparam logic [OW-1:0] OUT_MAX = {OW{1'b1}};

    typedef struct packed {
        t_diff [2:0] u;
        t_diff [2:0] v;
        t_diff [2:0] w;
    } t_geo;

    typedef struct packed {
        t_dot a;
        t_dot b;
        t_dot c;
        t_dot d;
        t_dot e;
        t_geo geo;
    } t_dots;

    typedef struct packed {
        t_dot a;
        t_dot nd;
        t_dot bmd;
        logic nd_neg;
        logic nd_gt;
        logic bd_neg;
        logic bd_gt;
        t_geo geo;
    } t_alt;

    typedef struct packed {
        t_wide      sn;
        t_wide      sd;
        t_wide      tn;
        t_wide      td;
        logic [1:0] ss;
        logic [1:0] ts;
    } t_frac;

    function automatic t_uwide tiny_lim(input logic [1:0] scale);
        t_uwide lim;
        case (scale)
            SC_INT:  lim = TINY_INT;
            SC_F2:   lim = TINY_F2;
            SC_F4:   lim = TINY_F4;
            default: lim = TINY_INT;
        endcase
        return lim;
    endfunction

endpackage

// File: rtl/ssd_mul.sv
// pipelined signed 68x68 multiplier built from four 34x34 partial products
module ssd_mul import ssd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_dot  i_a,
    input  t_dot  i_b,
    output logic  o_valid,
    output t_wide o_prod
);

    logic [PW-1:0]      n_ma;
    logic [PW-1:0]      n_mb;
    logic [2*HW-1:0]    r_ll;
    logic [2*HW-1:0]    r_lh;
    logic [2*HW-1:0]    r_hl;
    logic [2*HW-1:0]    r_hh;
    logic               r_neg1;
    logic               r_neg2;
    t_uwide             r_mag;
    t_wide              r_prod;
    logic [MUL_LAT-1:0] r_v;

    assign n_ma = i_a[PW-1] ? PW'(-i_a) : PW'(i_a);
    assign n_mb = i_b[PW-1] ? PW'(-i_b) : PW'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[MUL_LAT-2:0], i_valid};
        end
        r_ll   <= n_ma[HW-1:0] * n_mb[HW-1:0];
        r_lh   <= n_ma[HW-1:0] * n_mb[PW-1:HW];
        r_hl   <= n_ma[PW-1:HW] * n_mb[HW-1:0];
        r_hh   <= n_ma[PW-1:HW] * n_mb[PW-1:HW];
        r_neg1 <= i_a[PW-1] ^ i_b[PW-1];
        r_mag  <= WW'(r_ll) + (WW'(r_lh) << HW) + (WW'(r_hl) << HW) + (WW'(r_hh) << PW);
        r_neg2 <= r_neg1;
        r_prod <= r_neg2 ? -$signed(r_mag) : $signed(r_mag);
    end

    assign o_valid = r_v[MUL_LAT-1];
    assign o_prod  = r_prod;

endmodule

// File: rtl/ssd_div.sv
// pipelined restoring divider, one quotient bit per stage, quotient num*2^32/den
module ssd_div import ssd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_uwide i_num,
    input  t_uwide i_den,
    output logic   o_valid,
    output t_quo   o_quo
);

    t_uwide             r_rem [DIV_LAT];
    t_uwide             r_den [DIV_LAT];
    t_quo               r_quo [DIV_LAT];
    logic [DIV_LAT-1:0] r_v;
    logic               n_top;

    assign n_top = i_num >= i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DIV_LAT-2:0], i_valid};
        end
        r_rem[0] <= n_top ? i_num - i_den : i_num;
        r_den[0] <= i_den;
        r_quo[0] <= QW'(n_top);
    end

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
        t_uwide n_shl;
        logic   n_ge;
        assign n_shl = {r_rem[k-1][WW-2:0], 1'b0};
        assign n_ge  = n_shl >= r_den[k-1];
        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? n_shl - r_den[k-1] : n_shl;
            r_den[k] <= r_den[k-1];
            r_quo[k] <= {r_quo[k-1][QW-2:0], n_ge};
        end
    end

    assign o_valid = r_v[DIV_LAT-1];
    assign o_quo   = r_quo[DIV_LAT-1];

endmodule

// File: rtl/ssd_sqrt.sv
// pipelined integer square root, one root bit per stage
module ssd_sqrt import ssd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [SW-1:0] i_rad,
    output logic          o_valid,
    output logic [RW-1:0] o_root
);

    logic [SW-1:0]       r_rad  [SQRT_LAT];
    logic [RW+3:0]       r_rem  [SQRT_LAT];
    logic [RW-1:0]       r_root [SQRT_LAT];
    logic [SQRT_LAT-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[SQRT_LAT-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
        logic [SW-1:0] p_rad;
        logic [RW+3:0] p_rem;
        logic [RW-1:0] p_root;
        logic [RW+3:0] n_remx;
        logic [RW+3:0] n_trial;
        logic          n_ge;
        if (k == 0) begin : g_first
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
        end
        assign n_remx  = {p_rem[RW+1:0], p_rad[SW-1 -: 2]};
        assign n_trial = {2'b00, p_root, 2'b01};
        assign n_ge    = n_remx >= n_trial;
        always_ff @(posedge i_clk) begin
            r_rad[k]  <= {p_rad[SW-3:0], 2'b00};
            r_rem[k]  <= n_ge ? n_remx - n_trial : n_remx;
            r_root[k] <= {p_root[RW-2:0], n_ge};
        end
    end

    assign o_valid = r_v[SQRT_LAT-1];
    assign o_root  = r_root[SQRT_LAT-1];

endmodule

// File: rtl/segment_segment_distance_3d_core.sv
// minimum distance between two 3d segments, fully pipelined
// throughput: one word per cycle, busy stays low; the pipeline includes the
// 33-stage divider and the 36-stage square root
// reset: synchronous active-low reset clears all valid bits; no results follow
module segment_segment_distance_3d_core import ssd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_coord        i_first_start_x,
    input  t_coord        i_first_start_y,
    input  t_coord        i_first_start_z,
    input  t_coord        i_first_end_x,
    input  t_coord        i_first_end_y,
    input  t_coord        i_first_end_z,
    input  t_coord        i_second_start_x,
    input  t_coord        i_second_start_y,
    input  t_coord        i_second_start_z,
    input  t_coord        i_second_end_x,
    input  t_coord        i_second_end_y,
    input  t_coord        i_second_end_z,
    output logic          o_valid,
    output logic [OW-1:0] o_min_distance
);

    t_coord n_p0 [3];
    t_coord n_p1 [3];
    t_coord n_q0 [3];
    t_coord n_q1 [3];

    logic                    r1_v;
    t_geo                    r1_geo;
    logic                    r2_v;
    t_geo                    r2_geo;
    logic signed [2*DW-1:0]  r2_uu [3];
    logic signed [2*DW-1:0]  r2_uv [3];
    logic signed [2*DW-1:0]  r2_vv [3];
    logic signed [2*DW-1:0]  r2_uw [3];
    logic signed [2*DW-1:0]  r2_vw [3];
    logic                    r3_v;
    t_dots                   r3_s;
    t_dots                   r_sm [MUL_LAT];

    logic [5:0] m_v;
    t_wide      m_ac;
    t_wide      m_bb;
    t_wide      m_be;
    t_wide      m_cd;
    t_wide      m_ae;
    t_wide      m_bd;

    logic  r4_v;
    t_wide r4_dd;
    t_wide r4_sn;
    t_wide r4_tn;
    t_dot  r4_eb;
    t_dot  r4_nd;
    t_dot  r4_bmd;
    t_dots r4_side;

    logic  r5_v;
    logic  r5_par;
    logic  r5_sneg;
    logic  r5_sgt;
    t_wide r5_dd;
    t_wide r5_sn;
    t_wide r5_tn;
    t_dot  r5_e;
    t_dot  r5_c;
    t_dot  r5_eb;
    t_alt  r5_alt;

    t_frac n6_f;
    logic  r6_v;
    t_frac r6_f;
    t_alt  r6_alt;

    logic  r7_v;
    logic  r7_tneg;
    logic  r7_tgt;
    t_frac r7_f;
    t_alt  r7_alt;

    t_frac n8_f;
    t_dot  n8_alt;
    logic  n8_aneg;
    logic  n8_agt;
    logic  r8_v;
    t_frac r8_f;
    t_geo  r8_geo;

    logic   n9_sok;
    logic   n9_tok;
    logic   r9_v;
    t_uwide r9_sn;
    t_uwide r9_sd;
    t_uwide r9_tn;
    t_uwide r9_td;
    t_geo   r_sd [DIV_LAT+1];

    logic [1:0] d_v;
    t_quo       d_s;
    t_quo       d_t;

    logic                      r10_v;
    logic signed [DW+QW:0]     r10_pu [3];
    logic signed [DW+QW:0]     r10_pv [3];
    t_diff                     r10_w  [3];
    logic                      r11_v;
    t_dot                      r11_k  [3];

    logic [2:0] q_v;
    t_wide      q_sq [3];

    logic          r12_v;
    t_wide         r12_sum;
    logic          s_v;
    logic [RW-1:0] s_root;
    logic          r_ov;
    logic [OW-1:0] r_dist;

    assign busy = 1'b0;

    assign n_p0[0] = i_first_start_x;
    assign n_p0[1] = i_first_start_y;
    assign n_p0[2] = i_first_start_z;
    assign n_p1[0] = i_first_end_x;
    assign n_p1[1] = i_first_end_y;
    assign n_p1[2] = i_first_end_z;
    assign n_q0[0] = i_second_start_x;
    assign n_q0[1] = i_second_start_y;
    assign n_q0[2] = i_second_start_z;
    assign n_q1[0] = i_second_end_x;
    assign n_q1[1] = i_second_end_y;
    assign n_q1[2] = i_second_end_z;

    // direction vectors, offset, dot products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        for (int i = 0; i < 3; i++) begin
            r1_geo.u[i] <= DW'(n_p1[i]) - DW'(n_p0[i]);
            r1_geo.v[i] <= DW'(n_q1[i]) - DW'(n_q0[i]);
            r1_geo.w[i] <= DW'(n_p0[i]) - DW'(n_q0[i]);
            r2_uu[i] <= $signed(r1_geo.u[i]) * $signed(r1_geo.u[i]);
            r2_uv[i] <= $signed(r1_geo.u[i]) * $signed(r1_geo.v[i]);
            r2_vv[i] <= $signed(r1_geo.v[i]) * $signed(r1_geo.v[i]);
            r2_uw[i] <= $signed(r1_geo.u[i]) * $signed(r1_geo.w[i]);
            r2_vw[i] <= $signed(r1_geo.v[i]) * $signed(r1_geo.w[i]);
        end
        r2_geo   <= r1_geo;
        r3_s.a   <= PW'(r2_uu[0]) + PW'(r2_uu[1]) + PW'(r2_uu[2]);
        r3_s.b   <= PW'(r2_uv[0]) + PW'(r2_uv[1]) + PW'(r2_uv[2]);
        r3_s.c   <= PW'(r2_vv[0]) + PW'(r2_vv[1]) + PW'(r2_vv[2]);
        r3_s.d   <= PW'(r2_uw[0]) + PW'(r2_uw[1]) + PW'(r2_uw[2]);
        r3_s.e   <= PW'(r2_vw[0]) + PW'(r2_vw[1]) + PW'(r2_vw[2]);
        r3_s.geo <= r2_geo;
        r_sm[0]  <= r3_s;
        for (int k = 1; k < MUL_LAT; k++) begin
            r_sm[k] <= r_sm[k-1];
        end
    end

    ssd_mul u_mul_ac (.i_clk, .i_rst_n, .i_valid(r3_v), .i_a(r3_s.a), .i_b(r3_s.c),
                      .o_valid(m_v[0]), .o_prod(m_ac));
    ssd_mul u_mul_bb (.i_clk, .i_rst_n, .i_valid(r3_v), .i_a(r3_s.b), .i_b(r3_s.b),
                      .o_valid(m_v[1]), .o_prod(m_bb));
    ssd_mul u_mul_be (.i_clk, .i_rst_n, .i_valid(r3_v), .i_a(r3_s.b), .i_b(r3_s.e),
                      .o_valid(m_v[2]), .o_prod(m_be));
    ssd_mul u_mul_cd (.i_clk, .i_rst_n, .i_valid(r3_v), .i_a(r3_s.c), .i_b(r3_s.d),
                      .o_valid(m_v[3]), .o_prod(m_cd));
    ssd_mul u_mul_ae (.i_clk, .i_rst_n, .i_valid(r3_v), .i_a(r3_s.a), .i_b(r3_s.e),
                      .o_valid(m_v[4]), .o_prod(m_ae));
    ssd_mul u_mul_bd (.i_clk, .i_rst_n, .i_valid(r3_v), .i_a(r3_s.b), .i_b(r3_s.d),
                      .o_valid(m_v[5]), .o_prod(m_bd));

    // determinant, line numerators and clamp flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r4_v <= &m_v;
            r5_v <= r4_v;
        end
        r4_dd   <= m_ac - m_bb;
        r4_sn   <= m_be - m_cd;
        r4_tn   <= m_ae - m_bd;
        r4_eb   <= r_sm[MUL_LAT-1].e + r_sm[MUL_LAT-1].b;
        r4_nd   <= -r_sm[MUL_LAT-1].d;
        r4_bmd  <= r_sm[MUL_LAT-1].b - r_sm[MUL_LAT-1].d;
        r4_side <= r_sm[MUL_LAT-1];

        r5_par         <= $unsigned(r4_dd) < TINY_F4;
        r5_sneg        <= r4_sn[WW-1];
        r5_sgt         <= r4_sn > r4_dd;
        r5_dd          <= r4_dd;
        r5_sn          <= r4_sn;
        r5_tn          <= r4_tn;
        r5_e           <= r4_side.e;
        r5_c           <= r4_side.c;
        r5_eb          <= r4_eb;
        r5_alt.a       <= r4_side.a;
        r5_alt.nd      <= r4_nd;
        r5_alt.bmd     <= r4_bmd;
        r5_alt.nd_neg  <= r4_nd[PW-1];
        r5_alt.nd_gt   <= r4_nd > r4_side.a;
        r5_alt.bd_neg  <= r4_bmd[PW-1];
        r5_alt.bd_gt   <= r4_bmd > r4_side.a;
        r5_alt.geo     <= r4_side.geo;
    end

    // parallel case and clamp of s
    always_comb begin
        n6_f.sn = '0;
        n6_f.sd = r5_dd;
        n6_f.ss = SC_F4;
        n6_f.tn = WW'(r5_e);
        n6_f.td = WW'(r5_c);
        n6_f.ts = SC_F2;
        if (r5_par) begin
            n6_f.sd = WW'(1);
            n6_f.ss = SC_INT;
        end else if (r5_sneg) begin
            n6_f.sn = '0;
        end else if (r5_sgt) begin
            n6_f.sn = r5_dd;
            n6_f.tn = WW'(r5_eb);
        end else begin
            n6_f.sn = r5_sn;
            n6_f.tn = r5_tn;
            n6_f.td = r5_dd;
            n6_f.ts = SC_F4;
        end
    end

    // clamp of t with s worked out again
    always_comb begin
        n8_f    = r7_f;
        n8_alt  = r7_tneg ? r7_alt.nd : r7_alt.bmd;
        n8_aneg = r7_tneg ? r7_alt.nd_neg : r7_alt.bd_neg;
        n8_agt  = r7_tneg ? r7_alt.nd_gt : r7_alt.bd_gt;
        if (r7_tneg || r7_tgt) begin
            n8_f.tn = r7_tneg ? '0 : r7_f.td;
            if (n8_aneg) begin
                n8_f.sn = '0;
            end else if (n8_agt) begin
                n8_f.sn = r7_f.sd;
            end else begin
                n8_f.sn = WW'(n8_alt);
                n8_f.sd = WW'(r7_alt.a);
                n8_f.ss = SC_F2;
            end
        end
    end

    assign n9_sok = ($unsigned(r8_f.sn) >= tiny_lim(r8_f.ss)) && (r8_f.sd != '0);
    assign n9_tok = ($unsigned(r8_f.tn) >= tiny_lim(r8_f.ts)) && (r8_f.td != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
        r6_f    <= n6_f;
        r6_alt  <= r5_alt;
        r7_tneg <= r6_f.tn[WW-1];
        r7_tgt  <= r6_f.tn > r6_f.td;
        r7_f    <= r6_f;
        r7_alt  <= r6_alt;
        r8_f    <= n8_f;
        r8_geo  <= r7_alt.geo;
        r9_sn   <= n9_sok ? $unsigned(r8_f.sn) : '0;
        r9_sd   <= n9_sok ? $unsigned(r8_f.sd) : WW'(1);
        r9_tn   <= n9_tok ? $unsigned(r8_f.tn) : '0;
        r9_td   <= n9_tok ? $unsigned(r8_f.td) : WW'(1);
        r_sd[0] <= r8_geo;
        for (int k = 1; k < DIV_LAT + 1; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    ssd_div u_div_s (.i_clk, .i_rst_n, .i_valid(r9_v), .i_num(r9_sn), .i_den(r9_sd),
                     .o_valid(d_v[0]), .o_quo(d_s));
    ssd_div u_div_t (.i_clk, .i_rst_n, .i_valid(r9_v), .i_num(r9_tn), .i_den(r9_td),
                     .o_valid(d_v[1]), .o_quo(d_t));

    // closest-point difference vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
            r11_v <= 1'b0;
        end else begin
            r10_v <= &d_v;
            r11_v <= r10_v;
        end
        for (int i = 0; i < 3; i++) begin
            r10_pu[i] <= $signed({1'b0, d_s}) * $signed(r_sd[DIV_LAT].u[i]);
            r10_pv[i] <= $signed({1'b0, d_t}) * $signed(r_sd[DIV_LAT].v[i]);
            r10_w[i]  <= r_sd[DIV_LAT].w[i];
            r11_k[i]  <= PW'($signed({r10_w[i], 32'b0})) + PW'(r10_pu[i]) - PW'(r10_pv[i]);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_sq
        ssd_mul u_mul_sq (.i_clk, .i_rst_n, .i_valid(r11_v), .i_a(r11_k[i]), .i_b(r11_k[i]),
                          .o_valid(q_v[i]), .o_prod(q_sq[i]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else begin
            r12_v <= &q_v;
        end
        r12_sum <= q_sq[0] + q_sq[1] + q_sq[2];
    end

    ssd_sqrt u_sqrt (.i_clk, .i_rst_n, .i_valid(r12_v), .i_rad(r12_sum[WW-1 -: SW]),
                     .o_valid(s_v), .o_root(s_root));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= s_v;
        end
        r_dist <= (s_root > RW'(OUT_MAX)) ? OUT_MAX : s_root[OW-1:0];
    end

    assign o_valid        = r_ov;
    assign o_min_distance = r_dist;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("accepted word produced no result at the expected cycle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result strobe without an accepted word");

    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_v[0] == d_v[1] && q_v[0] == q_v[2])
        else $error("parallel units out of step");

endmodule
